// File: sv/lcal_pkg.sv
package lcal_pkg;

  localparam int unsigned LCAL_NODES = 1024;
  localparam int unsigned LCAL_LOG   = 10;

  localparam int unsigned NODE_W  = 10;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned OP_W    = 2;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [OP_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  // one jump table entry: ancestor present and its node number
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } jent_t;

  typedef struct packed {
    kind_e             kind;
    logic [NODE_W-1:0] ancestor;
  } res_t;

endpackage

// File: sv/lowest_common_ancestor_lifting_core.sv
// load writes the parent and depth of one node; query swaps so u is deeper,
// lifts u by the depth difference, then lifts both nodes jointly on the
// two-port jump table; build fills each level above 0 for nodes below node_count
// one request in work at a time; the next is taken once the result is registered
// reset clears control state and sets node_count to 1; jump table and depth
// store hold nothing valid until loaded and built, there is no clearing pass
module lowest_common_ancestor_lifting_core import lcal_pkg::*; #(
  parameter int unsigned NODES = LCAL_NODES,
  parameter int unsigned LOG   = LCAL_LOG
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // node_a, node_b, has_parent, node_depth
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [OP_W-1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // ancestor
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic [OP_W-1:0]        m_axis_tuser
);

  localparam int unsigned AW     = $clog2(NODES);
  localparam int unsigned LW     = (LOG > 1) ? $clog2(LOG) : 1;
  localparam int unsigned JDEPTH = LOG * (1 << AW);

  logic               jm_we;
  logic [LW+AW-1:0]   jm_waddr, jm_raddr_a, jm_raddr_b;
  jent_t              jm_wdata, jm_rdata_a, jm_rdata_b;
  logic               dm_we;
  logic [AW-1:0]      dm_waddr, dm_raddr_a, dm_raddr_b;
  logic [DEPTH_W-1:0] dm_wdata, dm_rdata_a, dm_rdata_b;

  logic               res_valid, res_ready;
  res_t               res;
  logic               m_valid_q;
  res_t               m_res_q;

  lcal_ctrl #(
    .NODES (NODES),
    .LOG   (LOG),
    .AW    (AW),
    .LW    (LW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_a_i       (s_axis_tdata[9:0]),
    .in_b_i       (s_axis_tdata[19:10]),
    .in_par_i     (s_axis_tdata[20]),
    .in_dep_i     (s_axis_tdata[30:21]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .jm_we_o      (jm_we),
    .jm_waddr_o   (jm_waddr),
    .jm_wdata_o   (jm_wdata),
    .jm_raddr_a_o (jm_raddr_a),
    .jm_raddr_b_o (jm_raddr_b),
    .jm_rdata_a_i (jm_rdata_a),
    .jm_rdata_b_i (jm_rdata_b),
    .dm_we_o      (dm_we),
    .dm_waddr_o   (dm_waddr),
    .dm_wdata_o   (dm_wdata),
    .dm_raddr_a_o (dm_raddr_a),
    .dm_raddr_b_o (dm_raddr_b),
    .dm_rdata_a_i (dm_rdata_a),
    .dm_rdata_b_i (dm_rdata_b)
  );

  lcal_ram #(
    .DW    ($bits(jent_t)),
    .AW    (LW + AW),
    .DEPTH (JDEPTH)
  ) u_jump_ram (
    .clk_i     (clk_i),
    .we_i      (jm_we),
    .waddr_i   (jm_waddr),
    .wdata_i   (jm_wdata),
    .raddr_a_i (jm_raddr_a),
    .raddr_b_i (jm_raddr_b),
    .rdata_a_o (jm_rdata_a),
    .rdata_b_o (jm_rdata_b)
  );

  lcal_ram #(
    .DW    (DEPTH_W),
    .AW    (AW),
    .DEPTH (NODES)
  ) u_depth_ram (
    .clk_i     (clk_i),
    .we_i      (dm_we),
    .waddr_i   (dm_waddr),
    .wdata_i   (dm_wdata),
    .raddr_a_i (dm_raddr_a),
    .raddr_b_i (dm_raddr_b),
    .rdata_a_o (dm_rdata_a),
    .rdata_b_o (dm_rdata_b)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_res_q.ancestor);
  assign m_axis_tuser  = m_res_q.kind;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(res_valid && res_ready))
    else $error("result shown without a finished request");

endmodule

// File: sv/lcal_ram.sv
module lcal_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned AW    = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_a_q;
  logic [DW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// File: sv/lcal_ctrl.sv
module lcal_ctrl import lcal_pkg::*; #(
  parameter int unsigned NODES = LCAL_NODES,
  parameter int unsigned LOG   = LCAL_LOG,
  parameter int unsigned AW    = $clog2(NODES),
  parameter int unsigned LW    = (LOG > 1) ? $clog2(LOG) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    in_op_i,
  input  logic [NODE_W-1:0]  in_a_i,
  input  logic [NODE_W-1:0]  in_b_i,
  input  logic               in_par_i,
  input  logic [DEPTH_W-1:0] in_dep_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o,
  output logic               jm_we_o,
  output logic [LW+AW-1:0]   jm_waddr_o,
  output jent_t              jm_wdata_o,
  output logic [LW+AW-1:0]   jm_raddr_a_o,
  output logic [LW+AW-1:0]   jm_raddr_b_o,
  input  jent_t              jm_rdata_a_i,
  input  jent_t              jm_rdata_b_i,
  output logic               dm_we_o,
  output logic [AW-1:0]      dm_waddr_o,
  output logic [DEPTH_W-1:0] dm_wdata_o,
  output logic [AW-1:0]      dm_raddr_a_o,
  output logic [AW-1:0]      dm_raddr_b_o,
  input  logic [DEPTH_W-1:0] dm_rdata_a_i,
  input  logic [DEPTH_W-1:0] dm_rdata_b_i
);

  localparam int unsigned JW   = $clog2(LOG + 1);
  localparam int unsigned IW   = $clog2(NODES + 1);
  localparam int unsigned CMPW = (IW > CNT_W) ? IW : CNT_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SW   = 9'b000000010,
    S_LIFT = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_JEV  = 9'b000010000,
    S_FIN  = 9'b000100000,
    S_BLD  = 9'b001000000,
    S_BDR  = 9'b010000000,
    S_RES  = 9'b100000000
  } state_e;

  state_e             st_q, st_d;
  logic [CNT_W-1:0]   cfg_q;
  logic               pend_q, pend_d;
  logic               p1_q, p1_d;
  logic               p2_q;
  logic [AW-1:0]      i1_q, i1_d;
  logic [AW-1:0]      i2_q;
  logic               v2_q;
  logic [IW-1:0]      i_q, i_d;
  logic [LW-1:0]      lvl_q, lvl_d;
  logic [JW-1:0]      j_q, j_d;
  logic [NODE_W-1:0]  u_q, u_d, v_q, v_d;
  logic [DEPTH_W-1:0] diff_q, diff_d;
  kind_e              kind_q, kind_d;
  logic [NODE_W-1:0]  ans_q, ans_d;

  logic               a_ok, b_ok, b_in, issue_ok, take;
  logic [NODE_W-1:0]  u_eff, un, vn;
  logic [DEPTH_W-1:0] diff_sh;

  assign a_ok     = (CNT_W'(in_a_i) < cfg_q) && (32'(in_a_i) < NODES);
  assign b_ok     = (CNT_W'(in_b_i) < cfg_q) && b_in;
  assign b_in     = 32'(in_b_i) < NODES;
  assign issue_ok = (CMPW'(i_q) < CMPW'(cfg_q)) && (32'(i_q) < NODES);
  assign u_eff    = (pend_q && jm_rdata_a_i.valid) ? jm_rdata_a_i.node : u_q;
  assign diff_sh  = diff_q >> j_q;
  assign take     = jm_rdata_a_i.valid && jm_rdata_b_i.valid &&
                    (jm_rdata_a_i.node != jm_rdata_b_i.node);
  assign un       = take ? jm_rdata_a_i.node : u_q;
  assign vn       = take ? jm_rdata_b_i.node : v_q;

  always_comb begin
    st_d         = st_q;
    pend_d       = 1'b0;
    p1_d         = 1'b0;
    i1_d         = i1_q;
    i_d          = i_q;
    lvl_d        = lvl_q;
    j_d          = j_q;
    u_d          = u_q;
    v_d          = v_q;
    diff_d       = diff_q;
    kind_d       = kind_q;
    ans_d        = ans_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    jm_we_o      = 1'b0;
    jm_waddr_o   = {lvl_q, i2_q};
    jm_wdata_o   = v2_q ? jm_rdata_b_i : '0;
    jm_raddr_a_o = {lvl_q, AW'(u_q)};
    jm_raddr_b_o = {lvl_q, AW'(v_q)};
    dm_we_o      = 1'b0;
    dm_waddr_o   = AW'(in_a_i);
    dm_wdata_o   = in_dep_i;
    dm_raddr_a_o = AW'(in_a_i);
    dm_raddr_b_o = AW'(in_b_i);

    // build pipeline, second and third stage
    if (p1_q) begin
      jm_raddr_b_o = {LW'(lvl_q - 1'b1), AW'(jm_rdata_a_i.node)};
    end
    if (p2_q) begin
      jm_we_o = 1'b1;
    end

    case (st_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            OP_LOAD: begin
              if (a_ok) begin
                jm_we_o         = 1'b1;
                jm_waddr_o      = {LW'(0), AW'(in_a_i)};
                jm_wdata_o      = '0;
                jm_wdata_o.valid = in_par_i && b_in;
                jm_wdata_o.node = (in_par_i && b_in) ? in_b_i : '0;
                dm_we_o         = 1'b1;
              end
              kind_d = KIND_LOAD;
              ans_d  = '0;
              st_d   = S_RES;
            end
            OP_BUILD: begin
              kind_d = KIND_BUILD;
              ans_d  = '0;
              lvl_d  = LW'(1);
              i_d    = '0;
              st_d   = (LOG > 1) ? S_BLD : S_RES;
            end
            OP_QUERY: begin
              kind_d = KIND_QUERY;
              u_d    = in_a_i;
              v_d    = in_b_i;
              if (!(a_ok && b_ok)) begin
                ans_d = '0;
                st_d  = S_RES;
              end else if (in_a_i == in_b_i) begin
                ans_d = in_a_i;
                st_d  = S_RES;
              end else begin
                st_d = S_SW;
              end
            end
            default: begin
              st_d = S_IDLE;
            end
          endcase
        end
      end
      S_SW: begin
        if (dm_rdata_a_i < dm_rdata_b_i) begin
          u_d    = v_q;
          v_d    = u_q;
          diff_d = dm_rdata_b_i - dm_rdata_a_i;
        end else begin
          diff_d = dm_rdata_a_i - dm_rdata_b_i;
        end
        j_d  = '0;
        st_d = S_LIFT;
      end
      S_LIFT: begin
        u_d = u_eff;
        if (j_q == JW'(LOG)) begin
          st_d = S_CHK;
        end else begin
          if (diff_sh[0]) begin
            jm_raddr_a_o = {LW'(j_q), AW'(u_eff)};
            pend_d       = 1'b1;
          end
          j_d = j_q + 1'b1;
        end
      end
      S_CHK: begin
        if (u_q == v_q) begin
          ans_d = u_q;
          st_d  = S_RES;
        end else begin
          jm_raddr_a_o = {LW'(LOG - 1), AW'(u_q)};
          jm_raddr_b_o = {LW'(LOG - 1), AW'(v_q)};
          lvl_d        = LW'(LOG - 1);
          st_d         = S_JEV;
        end
      end
      S_JEV: begin
        u_d = un;
        v_d = vn;
        if (lvl_q == '0) begin
          jm_raddr_a_o = {LW'(0), AW'(un)};
          st_d         = S_FIN;
        end else begin
          jm_raddr_a_o = {LW'(lvl_q - 1'b1), AW'(un)};
          jm_raddr_b_o = {LW'(lvl_q - 1'b1), AW'(vn)};
          lvl_d        = lvl_q - 1'b1;
        end
      end
      S_FIN: begin
        ans_d = jm_rdata_a_i.valid ? jm_rdata_a_i.node : '0;
        st_d  = S_RES;
      end
      S_BLD: begin
        if (issue_ok) begin
          jm_raddr_a_o = {LW'(lvl_q - 1'b1), AW'(i_q)};
          p1_d         = 1'b1;
          i1_d         = AW'(i_q);
          i_d          = i_q + 1'b1;
        end else begin
          st_d = S_BDR;
        end
      end
      S_BDR: begin
        if (!p1_q && !p2_q) begin
          if (lvl_q == LW'(LOG - 1)) begin
            st_d = S_RES;
          end else begin
            lvl_d = lvl_q + 1'b1;
            i_d   = '0;
            st_d  = S_BLD;
          end
        end
      end
      S_RES: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  assign res_o = '{kind: kind_q, ancestor: ans_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cfg_q  <= CNT_W'(1);
      pend_q <= 1'b0;
      p1_q   <= 1'b0;
      p2_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      pend_q <= pend_d;
      p1_q   <= p1_d;
      p2_q   <= p1_q;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q   <= i1_d;
    i2_q   <= i1_q;
    v2_q   <= jm_rdata_a_i.valid;
    i_q    <= i_d;
    lvl_q  <= lvl_d;
    j_q    <= j_d;
    u_q    <= u_d;
    v_q    <= v_d;
    diff_q <= diff_d;
    kind_q <= kind_d;
    ans_q  <= ans_d;
  end

  // build pipeline is empty whenever a new request can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> (!p1_q && !p2_q))
    else $error("build pipeline busy while idle");

  // table writes only from a load or the last build stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    jm_we_o |-> ((st_q == S_IDLE && in_valid_i) || p2_q))
    else $error("unexpected jump table write");

  // lift level never runs past the table height
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_LIFT) |-> (j_q <= JW'(LOG)))
    else $error("lift level out of range");

endmodule
